### src/xnp_pkg.sv
// Shared constants and types for the XNOR-popcount binary matrix multiply.
// Used by xnp_popacc, the top level and the bench; depends on nothing.
package xnp_pkg;

  // Packed word geometry
  localparam int WORD_BITS = 32;
  localparam int WB_LOG2   = 5;

  // Port widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  // Request kinds carried in in_tuser
  localparam logic [1:0] FN_WR_A    = 2'd0;
  localparam logic [1:0] FN_WR_B    = 2'd1;
  localparam logic [1:0] FN_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VLEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CCNT = 1'b1;

  // Register reset values
  localparam logic [8:0] VLEN_RST = 9'd256;
  localparam logic [4:0] CCNT_RST = 5'd16;

  // Control from the sequencer to the popcount accumulator
  typedef struct packed {
    logic clr;   // start a new column sum
    logic en;    // a word pair is on the read ports
    logic last;  // that pair is the final word of the vector
  } popacc_ctl_t;

endpackage

### src/xnp_wmem.sv
// Word store: one write port, one read port with registered read data.
// Depends on nothing.
module xnp_wmem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/xnp_popacc.sv
// Shared XNOR / popcount unit with its running column sum.
// Depends on xnp_pkg for the word width and the control struct.
module xnp_popacc #(
  parameter int ACCW = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  xnp_pkg::popacc_ctl_t          ctl,
  input  logic [xnp_pkg::WORD_BITS-1:0] a_word,
  input  logic [xnp_pkg::WORD_BITS-1:0] b_word,
  input  logic [xnp_pkg::WORD_BITS-1:0] pad_mask,
  output logic [ACCW-1:0]               acc
);
  import xnp_pkg::*;

  localparam int PCW = WB_LOG2 + 1;

  logic [WORD_BITS-1:0] match;
  logic [PCW-1:0]       pop;
  logic [ACCW-1:0]      acc_r;
  logic [ACCW-1:0]      acc_nxt;

  function automatic logic [PCW-1:0] count_ones(input logic [WORD_BITS-1:0] v);
    logic [PCW-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + PCW'(v[i]);
    end
    return n;
  endfunction

  // Matching elements; padding bits of the final word count as matches
  always_comb begin
    match = ~(a_word ^ b_word);
    if (ctl.last) begin
      match = match | pad_mask;
    end
    pop = count_ones(match);
  end

  // Running sum of matches over the words of one column
  always_comb begin
    priority if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.en) begin
      acc_nxt = acc_r + ACCW'(pop);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### src/binary_xnor_popcount_matmul_top.sv
// Top level of the XNOR-popcount binary matrix multiply: ports, registers,
// sequencer and output register. Uses xnp_pkg, xnp_wmem and xnp_popacc.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: func; tdata: vector/word idx, bits
//  out_    | out | out_tvalid/out_tready| tdata: result_bit, column_index; tlast
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// Write words are taken while the sequencer is idle. A compute word walks the
// words of each column in turn, paced by the single read port of each word
// store and the one popcount unit; in_tready is low meanwhile.
// A stalled output register holds the sequencer at the end of a column.
// Reset clears control and loads vector_length 256, column_count 16; the
// word stores are not cleared and hold garbage until written.
module binary_xnor_popcount_matmul_top #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int MAX_WORDS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [xnp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] vector_index,
                                                       // [6:4] word_index,
                                                       // [38:7] packed_bits, [39] 0
  input  logic [xnp_pkg::IN_TUSER_W-1:0]   in_tuser,   // [1:0] func
  // result words
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [xnp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [0] result_bit,
                                                       // [4:1] column_index, [7:5] 0
  output logic                             out_tlast,  // last column of the row
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [xnp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xnp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import xnp_pkg::*;

  localparam int MaxLen = MAX_WORDS * WORD_BITS;
  localparam int AAW    = (MAX_ROWS * MAX_WORDS > 1) ? $clog2(MAX_ROWS * MAX_WORDS) : 1;
  localparam int BAW    = (MAX_COLS * MAX_WORDS > 1) ? $clog2(MAX_COLS * MAX_WORDS) : 1;
  localparam int NW     = $clog2(MAX_WORDS + 1);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int ACCW   = $clog2(MaxLen + 1);
  localparam int TW     = ACCW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_LAST  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Input fields
  logic [1:0]           in_func;
  logic [3:0]           in_vidx;
  logic [2:0]           in_widx;
  logic [WORD_BITS-1:0] in_bits;
  logic                 in_acc;

  // Registers
  logic [8:0] vlen_r;
  logic [4:0] ccnt_r;

  // Sequencer
  state_t               st_r, st_nxt;
  logic [NW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [NW-1:0]        nw_r, nw_nxt;
  logic [CW-1:0]        cols_r, cols_nxt;
  logic [TW-1:0]        thr_r, thr_nxt;
  logic [WORD_BITS-1:0] pmask_r, pmask_nxt;
  logic [AAW-1:0]       a_base_r, a_base_nxt;
  logic [BAW-1:0]       b_base_r, b_base_nxt;
  logic                 rd_vld_r, rd_last_r;
  logic                 start;
  logic                 word_last;
  logic                 col_last;

  // Request decode and clamps
  logic [8:0]           len_c;
  logic [4:0]           pad_c;
  logic [CW-1:0]        cols_c;

  // Stores and datapath
  logic                 a_we, b_we;
  logic [AAW-1:0]       a_waddr, a_raddr;
  logic [BAW-1:0]       b_waddr, b_raddr;
  logic [WORD_BITS-1:0] a_rdata, b_rdata;
  popacc_ctl_t          pa_ctl;
  logic [ACCW-1:0]      acc;

  // Output register
  logic                 out_load;
  logic                 out_valid_r, out_valid_nxt;
  logic                 res_r;
  logic [3:0]           ocol_r;
  logic                 olast_r;

  assign in_func = in_tuser[1:0];
  assign in_vidx = in_tdata[3:0];
  assign in_widx = in_tdata[6:4];
  assign in_bits = in_tdata[38:7];

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_RST;
      ccnt_r <= CCNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VLEN: vlen_r <= cfg_data;
        REG_CCNT: ccnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Store writes
  always_comb begin
    a_we    = in_acc && (in_func == FN_WR_A) && (32'(in_vidx) < MAX_ROWS)
              && (32'(in_widx) < MAX_WORDS);
    b_we    = in_acc && (in_func == FN_WR_B) && (32'(in_vidx) < MAX_COLS)
              && (32'(in_widx) < MAX_WORDS);
    a_waddr = AAW'(32'(in_vidx) * MAX_WORDS + 32'(in_widx));
    b_waddr = BAW'(32'(in_vidx) * MAX_WORDS + 32'(in_widx));
  end

  // Clamp registers and derive the padding
  always_comb begin
    priority if (vlen_r == 9'd0) begin
      len_c = 9'd1;
    end else if (32'(vlen_r) > MaxLen) begin
      len_c = 9'(MaxLen);
    end else begin
      len_c = vlen_r;
    end
    pad_c = 5'(~len_c[4:0]) + 5'd1;
    priority if (ccnt_r == 5'd0) begin
      cols_c = CW'(1);
    end else if (32'(ccnt_r) > MAX_COLS) begin
      cols_c = CW'(MAX_COLS);
    end else begin
      cols_c = CW'(ccnt_r);
    end
  end

  assign start     = in_acc && (in_func == FN_COMPUTE) && (32'(in_vidx) < MAX_ROWS);
  assign word_last = ({1'b0, k_r} + 1'b1) == {1'b0, nw_r};
  assign col_last  = ({1'b0, col_r} + 1'b1) == {1'b0, cols_r};
  assign out_load  = (st_r == S_EMIT) && (!out_valid_r || out_tready);

  // Sequencer: walk words of each column, then emit one result
  always_comb begin
    st_nxt     = st_r;
    k_nxt      = k_r;
    col_nxt    = col_r;
    nw_nxt     = nw_r;
    cols_nxt   = cols_r;
    thr_nxt    = thr_r;
    pmask_nxt  = pmask_r;
    a_base_nxt = a_base_r;
    b_base_nxt = b_base_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt     = S_ISSUE;
          k_nxt      = '0;
          col_nxt    = '0;
          nw_nxt     = NW'((10'({1'b0, len_c}) + 10'(WORD_BITS - 1)) >> WB_LOG2);
          cols_nxt   = cols_c;
          thr_nxt    = TW'(32'(len_c) + 2 * 32'(pad_c));
          pmask_nxt  = ~({WORD_BITS{1'b1}} << pad_c);
          a_base_nxt = AAW'(32'(in_vidx) * MAX_WORDS);
          b_base_nxt = '0;
        end
      end
      S_ISSUE: begin
        if (word_last) begin
          k_nxt  = '0;
          st_nxt = S_LAST;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_LAST: begin
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          col_nxt    = col_r + 1'b1;
          b_base_nxt = b_base_r + BAW'(MAX_WORDS);
          st_nxt     = col_last ? S_IDLE : S_ISSUE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      k_r       <= '0;
      col_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      k_r       <= k_nxt;
      col_r     <= col_nxt;
      rd_vld_r  <= (st_r == S_ISSUE);
      rd_last_r <= (st_r == S_ISSUE) && word_last;
    end
  end

  // Request payload, no reset needed
  always_ff @(posedge clk) begin
    nw_r     <= nw_nxt;
    cols_r   <= cols_nxt;
    thr_r    <= thr_nxt;
    pmask_r  <= pmask_nxt;
    a_base_r <= a_base_nxt;
    b_base_r <= b_base_nxt;
  end

  // Read addresses for the current word pair
  assign a_raddr = a_base_r + AAW'(k_r);
  assign b_raddr = b_base_r + BAW'(k_r);

  xnp_wmem #(
    .DEPTH (MAX_ROWS * MAX_WORDS),
    .AW    (AAW),
    .DW    (WORD_BITS)
  ) u_a_store (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (in_bits),
    .rd_addr (a_raddr),
    .rd_data (a_rdata)
  );

  xnp_wmem #(
    .DEPTH (MAX_COLS * MAX_WORDS),
    .AW    (BAW),
    .DW    (WORD_BITS)
  ) u_b_store (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (in_bits),
    .rd_addr (b_raddr),
    .rd_data (b_rdata)
  );

  // Accumulator control
  always_comb begin
    pa_ctl.clr  = start || out_load;
    pa_ctl.en   = rd_vld_r;
    pa_ctl.last = rd_last_r;
  end

  xnp_popacc #(
    .ACCW (ACCW)
  ) u_popacc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pa_ctl),
    .a_word   (a_rdata),
    .b_word   (b_rdata),
    .pad_mask (pmask_r),
    .acc      (acc)
  );

  // Output register; positive dot product means 2*matches > len + 2*pad
  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r   <= ({acc, 1'b0} > thr_r);
      ocol_r  <= 4'(32'(col_r));
      olast_r <= col_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, ocol_r, res_r};
  assign out_tlast  = olast_r;

  // Checks on the sequencer
  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == S_EMIT))
    else $error("result word loaded outside the emit state");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !(a_we || b_we))
    else $error("store written while a row is being computed");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && col_last) |=> (st_r == S_IDLE))
    else $error("sequencer did not return to idle after the final column");

  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ISSUE) |-> (k_r < nw_r))
    else $error("word counter ran past the vector length");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (acc == '0))
    else $error("column sum not cleared after a result was loaded");

endmodule

### bench/binary_xnor_popcount_matmul_top_tb.sv
// Self-checking bench for binary_xnor_popcount_matmul_top: loads A rows and B columns,
// issues row computes and checks every result bit against a local XNOR-popcount predictor.
// Depends on xnp_pkg and the top level in src, with the modules that it uses.
`timescale 1ns / 100ps

module binary_xnor_popcount_matmul_top_tb;
  import xnp_pkg::*;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int MAX_WORDS = 8;
  localparam int MAX_LEN   = MAX_WORDS * WORD_BITS;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES     = 16;
  localparam int END_DRAIN_CYCLES  = 200;  // longer than one full-size compute
  localparam int STALL_LIMIT       = 4000; // cycles without any handshake
  localparam int ITEMS_PER_SETTING = 15;

  // One result word as the block should emit it
  typedef struct packed {
    logic       result_bit;
    logic [3:0] column_index;
    logic       is_last;
  } col_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor copy of the stores, their written flags and the registers
  logic [31:0] a_rows  [MAX_ROWS][MAX_WORDS];
  logic [31:0] b_cols  [MAX_COLS][MAX_WORDS];
  bit          a_valid [MAX_ROWS][MAX_WORDS];
  bit          b_valid [MAX_COLS][MAX_WORDS];
  logic [8:0]  vlen_reg = VLEN_RST;
  logic [4:0]  ccnt_reg = CCNT_RST;

  col_result_t pending_bits[$];

  int error_count    = 0;
  int words_sent     = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  binary_xnor_popcount_matmul_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Effective register values after clamping
  function automatic int length_in_use();
    if (vlen_reg == 0) return 1;
    if (vlen_reg > MAX_LEN) return MAX_LEN;
    return int'(vlen_reg);
  endfunction

  function automatic int words_in_use();
    return (length_in_use() + WORD_BITS - 1) / WORD_BITS;
  endfunction

  function automatic int cols_in_use();
    if (ccnt_reg == 0) return 1;
    if (ccnt_reg > MAX_COLS) return MAX_COLS;
    return int'(ccnt_reg);
  endfunction

  // Sign of each XNOR-popcount dot product of one A row against the B columns
  function automatic void predict_row_bits(input logic [3:0] row);
    int          nwords, pad, cols, sum;
    logic [31:0] agree, pad_mask;
    col_result_t res;
    nwords   = words_in_use();
    cols     = cols_in_use();
    pad      = nwords * WORD_BITS - length_in_use();
    pad_mask = 32'((64'd1 << pad) - 1);  // padding sits in the low bits of the last word
    for (int c = 0; c < cols; c++) begin
      sum = 0;
      for (int k = 0; k < nwords; k++) begin
        agree = ~(a_rows[row][k] ^ b_cols[c][k]);
        if (k == nwords - 1) agree |= pad_mask;
        sum += 2 * $countones(agree) - WORD_BITS;
      end
      sum -= pad;
      res.result_bit   = (sum > 0);
      res.column_index = c[3:0];
      res.is_last      = (c == cols - 1);
      pending_bits.push_back(res);
    end
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Send one input word; tvalid stays high afterwards until the next caller lowers it
  task automatic send_word(input logic [1:0] fn, input logic [3:0] vidx,
                           input logic [2:0] widx, input logic [31:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {1'b0, bits, widx, vidx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (fn)
      FN_WR_A: begin
        a_rows[vidx][widx]  = bits;
        a_valid[vidx][widx] = 1'b1;
      end
      FN_WR_B: begin
        b_cols[vidx][widx]  = bits;
        b_valid[vidx][widx] = 1'b1;
      end
      FN_COMPUTE: predict_row_bits(vidx);
      default: ;
    endcase
    if (fn != FN_UNUSED) words_sent++;
  endtask

  // Stop sending, wait for every expected result, then let the block go quiet
  task automatic settle_idle(input int extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bits.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Both registers back to back; only called while the block is idle
  task automatic set_config(input logic [8:0] vlen_val, input logic [8:0] ccnt_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_VLEN;
    cfg_data  <= vlen_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vlen_reg = vlen_val;
    cfg_index <= REG_CCNT;
    cfg_data  <= ccnt_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ccnt_reg = ccnt_val[4:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic bit row_loaded(input int row);
    for (int k = 0; k < words_in_use(); k++)
      if (!a_valid[row][k]) return 1'b0;
    return 1'b1;
  endfunction

  // Write any B word that the next compute would read before it was written
  task automatic load_missing_columns();
    for (int c = 0; c < cols_in_use(); c++)
      for (int k = 0; k < words_in_use(); k++)
        if (!b_valid[c][k]) send_word(FN_WR_B, c[3:0], k[2:0], pick_word());
  endtask

  // Load an A row (or reuse it), make sure B is loaded, then compute it
  task automatic run_row_sequence();
    int row;
    row = $urandom_range(MAX_ROWS - 1);
    if ($urandom_range(3) != 0 || !row_loaded(row))
      for (int k = 0; k < words_in_use(); k++)
        send_word(FN_WR_A, row[3:0], k[2:0], pick_word());
    load_missing_columns();
    send_word(FN_COMPUTE, row[3:0], 3'($urandom), $urandom);
    if ($urandom_range(7) == 0) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (pending_bits.size() != 0);
    end
  endtask

  // 40-bit vectors: exact match with differing padding, full mismatch, a zero sum
  task automatic test_padding_and_ties();
    settle_idle(SETTLE_CYCLES);
    set_config(9'd40, 9'd3);
    send_word(FN_WR_A, 4'd15, 3'd0, 32'hFFFF_FFFF);
    send_word(FN_WR_A, 4'd15, 3'd1, 32'hFF5A_3C96);
    send_word(FN_WR_A, 4'd15, 3'd7, 32'h0000_0000);
    send_word(FN_WR_B, 4'd0, 3'd0, 32'hFFFF_FFFF);
    send_word(FN_WR_B, 4'd0, 3'd1, 32'hFFC3_A569);
    send_word(FN_WR_B, 4'd1, 3'd0, 32'h0000_0000);
    send_word(FN_WR_B, 4'd1, 3'd1, 32'h00A5_C369);
    send_word(FN_WR_B, 4'd2, 3'd0, 32'hFFFF_0000);
    send_word(FN_WR_B, 4'd2, 3'd1, 32'hF012_3456);
    send_word(FN_WR_B, 4'd15, 3'd7, 32'hFFFF_FFFF);
    // unused request kind must be dropped silently
    send_word(FN_UNUSED, 4'd15, 3'd7, 32'hDEAD_BEEF);
    send_word(FN_COMPUTE, 4'd15, 3'd0, 32'h0000_0000);
  endtask

  // Zero registers act as one bit and one column: +1 then -1
  task automatic test_zero_registers();
    settle_idle(SETTLE_CYCLES);
    set_config(9'd0, 9'd0);
    send_word(FN_COMPUTE, 4'd15, 3'd7, 32'hFFFF_FFFF);
    send_word(FN_WR_B, 4'd0, 3'd0, 32'h0000_0000);
    send_word(FN_COMPUTE, 4'd15, 3'd0, 32'h0000_0000);
  endtask

  // Random row traffic over several register settings and idle patterns
  task automatic test_random_traffic();
    int         sender_pct[4] = '{0, 57, 0, 21};
    int         stall_pct[4]  = '{0, 0, 57, 21};
    int         first_word, pick, col, wrd;
    logic [8:0] vlen_val, ccnt_val;
    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 2; s++) begin
        case (m * 2 + s)
          0: begin
            vlen_val = 9'($urandom_range(1, 64));
            ccnt_val = 9'($urandom_range(1, 16));
          end
          1: begin vlen_val = 9'd511;                 ccnt_val = 9'd31;                 end
          2: begin vlen_val = 9'd0;                   ccnt_val = 9'd0;                  end
          3: begin
            vlen_val = 9'($urandom_range(33, 96));
            ccnt_val = 9'($urandom_range(1, 16));
          end
          // upper data bits are outside the column count and must be dropped
          4: begin vlen_val = 9'd256;                 ccnt_val = 9'h1F0;                end
          5: begin
            vlen_val = 9'($urandom_range(1, 256));
            ccnt_val = 9'($urandom_range(0, 31));
          end
          6: begin vlen_val = 9'd32;                  ccnt_val = 9'd1;                  end
          default: begin
            vlen_val = 9'($urandom_range(1, 64));
            ccnt_val = 9'($urandom_range(1, 16));
          end
        endcase
        settle_idle(SETTLE_CYCLES);
        send_idle_pct  = sender_pct[m];
        recv_stall_pct = stall_pct[m];
        set_config(vlen_val, ccnt_val);
        first_word = words_sent;
        while (words_sent - first_word < ITEMS_PER_SETTING) begin
          pick = $urandom_range(99);
          if (pick < 65) begin
            run_row_sequence();
          end else if (pick < 80) begin
            col = $urandom_range(cols_in_use() - 1);
            wrd = $urandom_range(words_in_use() - 1);
            send_word(FN_WR_B, col[3:0], wrd[2:0], pick_word());
          end else if (pick < 92) begin
            // stray writes anywhere in either store
            send_word($urandom_range(1) ? FN_WR_B : FN_WR_A, 4'($urandom),
                      3'($urandom), pick_word());
          end else begin
            send_word(FN_UNUSED, 4'($urandom), 3'($urandom), $urandom);
          end
        end
      end
    end
  endtask

  // Receiver backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    col_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected result word tdata=%h tlast=%b",
                                  out_tdata, out_tlast));
      end else begin
        want = pending_bits.pop_front();
        if (out_tdata[0] !== want.result_bit)
          report_mismatch($sformatf("col %0d result_bit %b, want %b",
                                    want.column_index, out_tdata[0], want.result_bit));
        if (out_tdata[4:1] !== want.column_index)
          report_mismatch($sformatf("column_index %0d, want %0d",
                                    out_tdata[4:1], want.column_index));
        if (out_tlast !== want.is_last)
          report_mismatch($sformatf("col %0d tlast %b, want %b",
                                    want.column_index, out_tlast, want.is_last));
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_padding_and_ties();
    test_zero_registers();
    test_random_traffic();
    settle_idle(END_DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/xnp_pkg.sv
src/xnp_wmem.sv
src/xnp_popacc.sv
src/binary_xnor_popcount_matmul_top.sv
bench/binary_xnor_popcount_matmul_top_tb.sv
